FILE: rtl/u8u16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared constants and helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int unsigned UNIT_W   = 16;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned BURST_N  = 4;
	localparam int unsigned HELD_N   = 3;

	localparam logic [UNIT_W-1:0] REPL_UNIT    = 16'hFFFD;
	localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h10000;
	localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;

	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [2:0]        seq_len_t;
	typedef logic [2:0]        burst_cnt_t;

	localparam seq_len_t LEN_NONE = 3'd0;
	localparam seq_len_t LEN_TWO  = 3'd2;
	localparam seq_len_t LEN_THREE = 3'd3;
	localparam seq_len_t LEN_FOUR = 3'd4;

	// sequence length announced by a lead byte, LEN_NONE when not a lead
	function automatic seq_len_t lead_len(input logic [7:0] b);
		seq_len_t len;
		case (b) inside
			[8'hC0:8'hDF]: len = LEN_TWO;
			[8'hE0:8'hEF]: len = LEN_THREE;
			[8'hF0:8'hF7]: len = LEN_FOUR;
			default:       len = LEN_NONE;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/utf8_to_utf16_transcoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out, with U+FFFD for bad bytes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle as long as each byte gives at most one code unit
// and the output is not stalled. A byte that gives k units (a surrogate pair,
// or U+FFFD for each held byte of a broken sequence, up to four) keeps the
// next byte waiting while the output burst register hands out its units, one
// per cycle unless the output is stalled. A byte that only extends a sequence
// gives no unit and never waits for the output. A byte passes an input
// register, then the decode into the burst register. Overlong forms and
// encoded surrogates are passed through unchecked.
module utf8_to_utf16_transcoder_top (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   src_valid,
	output      logic                   src_stall,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   end_of_text,
	output      logic                   dst_valid,
	input  wire logic                   dst_stall,
	output      u8u16_pkg::unit_t       code_unit,
	output      logic                   is_replacement,
	output      logic                   run_last,
	output      logic                   text_last
);
	import u8u16_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// sequence state
	logic [7:0] held_q [HELD_N];
	logic [1:0] held_cnt_q;
	seq_len_t   exp_len_q;

	// output burst
	unit_t      buf_unit_q [BURST_N];
	logic       buf_repl_q [BURST_N];
	burst_cnt_t buf_cnt_q;
	logic       buf_eot_q;

	logic       src_acc, dst_acc, burst_free, move, load;

	// decode results
	burst_cnt_t n_rep;
	logic [1:0] tail_n;
	burst_cnt_t res_n;
	unit_t      tail_unit [2];
	logic       tail_repl;
	logic       hold_en;
	logic [1:0] hold_idx;
	logic [1:0] nxt_cnt;
	seq_len_t   nxt_len;
	unit_t      res_unit [BURST_N];
	logic       res_repl [BURST_N];

	logic       cont, lead_path;
	seq_len_t   blen;
	logic [CP_W-1:0] cp, adj;

	assign src_acc    = src_valid && !src_stall;
	assign dst_acc    = dst_valid && !dst_stall;
	assign burst_free = (buf_cnt_q == '0) || (buf_cnt_q == burst_cnt_t'(1) && dst_acc);
	assign move       = valid_s1 && (burst_free || res_n == '0);
	assign load       = move && res_n != '0;
	assign src_stall  = valid_s1 && !move;

	always_comb begin
		cont      = byte_s1[7:6] == 2'b10;
		blen      = lead_len(byte_s1);
		lead_path = !(held_cnt_q != '0 && cont);
		n_rep     = '0;
		tail_n    = '0;
		tail_unit[0] = REPL_UNIT;
		tail_unit[1] = REPL_UNIT;
		tail_repl = 1'b0;
		hold_en   = 1'b0;
		hold_idx  = '0;
		nxt_cnt   = held_cnt_q;
		nxt_len   = exp_len_q;

		case (exp_len_q)
			LEN_TWO:   cp = {10'd0, held_q[0][4:0], byte_s1[5:0]};
			LEN_THREE: cp = {5'd0, held_q[0][3:0], held_q[1][5:0], byte_s1[5:0]};
			default:   cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], byte_s1[5:0]};
		endcase
		adj = cp - SUPP_BASE;

		if (held_cnt_q != '0) begin
			if (cont) begin
				if ({1'b0, held_cnt_q} + 3'd1 == exp_len_q) begin
					if (cp < SUPP_BASE) begin
						tail_n       = 2'd1;
						tail_unit[0] = cp[UNIT_W-1:0];
					end else begin
						tail_n       = 2'd2;
						tail_unit[0] = SURR_HI_BASE + {5'd0, adj[20:10]};
						tail_unit[1] = SURR_LO_BASE + {6'd0, adj[9:0]};
					end
					nxt_cnt = '0;
					nxt_len = LEN_NONE;
				end else if (eot_s1) begin
					// cut off at the end: one replacement per held byte and this one
					n_rep   = {1'b0, held_cnt_q} + 3'd1;
					nxt_cnt = '0;
					nxt_len = LEN_NONE;
				end else begin
					hold_en  = 1'b1;
					hold_idx = held_cnt_q;
					nxt_cnt  = held_cnt_q + 2'd1;
				end
			end else begin
				n_rep   = {1'b0, held_cnt_q};
				nxt_cnt = '0;
				nxt_len = LEN_NONE;
			end
		end

		if (lead_path) begin
			if (!byte_s1[7]) begin
				tail_n       = 2'd1;
				tail_unit[0] = {8'd0, byte_s1};
			end else if (blen == LEN_NONE || eot_s1) begin
				tail_n    = 2'd1;
				tail_repl = 1'b1;
			end else begin
				hold_en  = 1'b1;
				hold_idx = '0;
				nxt_cnt  = 2'd1;
				nxt_len  = blen;
			end
		end

		res_n = n_rep + {1'b0, tail_n};

		for (int k = 0; k < BURST_N; k++) begin
			if (burst_cnt_t'(k) < n_rep) begin
				res_unit[k] = REPL_UNIT;
				res_repl[k] = 1'b1;
			end else if (burst_cnt_t'(k) == n_rep) begin
				res_unit[k] = tail_unit[0];
				res_repl[k] = tail_repl;
			end else begin
				res_unit[k] = tail_unit[1];
				res_repl[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_acc) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			byte_s1 <= in_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			exp_len_q  <= LEN_NONE;
		end else if (move) begin
			held_cnt_q <= nxt_cnt;
			exp_len_q  <= nxt_len;
		end
	end

	always_ff @(posedge clk) begin
		if (move && hold_en) begin
			held_q[hold_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (load) begin
			buf_cnt_q <= res_n;
		end else if (dst_acc) begin
			buf_cnt_q <= buf_cnt_q - burst_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_eot_q <= eot_s1;
			for (int k = 0; k < BURST_N; k++) begin
				buf_unit_q[k] <= res_unit[k];
				buf_repl_q[k] <= res_repl[k];
			end
		end else if (dst_acc) begin
			// shift the next unit to the head
			for (int k = 0; k < BURST_N - 1; k++) begin
				buf_unit_q[k] <= buf_unit_q[k+1];
				buf_repl_q[k] <= buf_repl_q[k+1];
			end
		end
	end

	assign dst_valid      = buf_cnt_q != '0;
	assign code_unit      = buf_unit_q[0];
	assign is_replacement = buf_repl_q[0];
	assign run_last       = buf_cnt_q == burst_cnt_t'(1);
	assign text_last      = run_last && buf_eot_q;

	// held count and announced length agree
	a_held_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != '0 |-> exp_len_q > {1'b0, held_cnt_q})
		else $error("held count not below announced length");

	a_idle_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q == '0 |-> exp_len_q == LEN_NONE)
		else $error("length kept with nothing held");

	a_burst_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_q <= burst_cnt_t'(BURST_N))
		else $error("burst count overflow");

	// end of text always flushes the sequence state
	a_eot_flush: assert property (@(posedge clk) disable iff (!arst_n)
		move && eot_s1 |=> held_cnt_q == '0)
		else $error("sequence state left after end of text");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && buf_cnt_q != '0)
		else $error("input stalled with empty pipeline");

endmodule
`default_nettype wire
